/* design/kmuf_pkg.sv */
// ----------------------------------------------------------------------------
// kmuf_pkg
// Shared widths and constants for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
package kmuf_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_W         = 21;
  localparam int VERTEX_W         = 6;
  localparam int COUNT_W          = 7;

  localparam logic [COUNT_W-1:0]  VCOUNT_RESET = 7'd4;
  localparam logic [WEIGHT_W-1:0] NO_EDGE      = 21'd999999;

endpackage

/* design/kmuf_ram.sv */
// ----------------------------------------------------------------------------
// kmuf_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kmuf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/kruskal_mst_union_find.sv */
// ----------------------------------------------------------------------------
// kruskal_mst_union_find
// Minimum spanning tree by Kruskal's method over a streamed adjacency matrix.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, weight) takes the adjacency matrix
//   row by row, vertex_count squared items. While loading, one item is taken
//   per cycle. Upper-triangle entries other than 999999 go to the edge memory.
//   After the last item in_ready drops until the final item of the run is
//   loaded into the output register. In between come an insertion sort in
//   the edge memory, a set-label init, then per edge a read of the edge and
//   of both endpoint labels, and per taken edge a hand-off of the previous
//   edge to the output register and a sweep that relabels the joined set.
//   Each memory has a single read port, so these steps run one at a time.
//   Results leave on out_valid/out_ready, one per taken edge, last on the
//   final one; with no edge taken a single item with edge_valid low and last
//   high is sent. A stalled receiver holds the output register and the
//   sequencer waits. vertex_count is written with cfg_we/cfg_wdata while
//   idle. Synchronous reset rst returns to loading with vertex_count 4.
// ----------------------------------------------------------------------------
module kruskal_mst_union_find #(
  parameter int MAX_VERTICES = kmuf_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kmuf_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kmuf_pkg::WEIGHT_W-1:0]  weight,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           edge_valid,
  output logic [kmuf_pkg::VERTEX_W-1:0]  src_vertex,
  output logic [kmuf_pkg::VERTEX_W-1:0]  dst_vertex,
  output logic [kmuf_pkg::WEIGHT_W-1:0]  edge_weight,
  output logic                           last
);

  localparam int DEPTH = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int WW    = kmuf_pkg::WEIGHT_W;
  localparam int EW    = 2 * VW + WW;

  typedef enum logic [13:0] {
    S_LOAD     = 14'b00000000000001,
    S_SRT_KEY  = 14'b00000000000010,
    S_SRT_GET  = 14'b00000000000100,
    S_SRT_PREV = 14'b00000000001000,
    S_SRT_CMP  = 14'b00000000010000,
    S_SRT_PUT  = 14'b00000000100000,
    S_INIT     = 14'b00000001000000,
    S_TEST     = 14'b00000010000000,
    S_EDGE     = 14'b00000100000000,
    S_RDA      = 14'b00001000000000,
    S_RDB      = 14'b00010000000000,
    S_EMIT     = 14'b00100000000000,
    S_SWEEP    = 14'b01000000000000,
    S_FLUSH    = 14'b10000000000000
  } state_t;

  state_t state;

  logic [kmuf_pkg::COUNT_W-1:0] vcount;
  logic [CW-1:0]  n_side;
  logic [CW-1:0]  n_run;
  logic [VW-1:0]  row;
  logic [VW-1:0]  col;
  logic [CW-1:0]  col_inc;
  logic [CW-1:0]  row_inc;
  logic [TW-1:0]  total;
  logic [TW-1:0]  i;
  logic [TW-1:0]  j;
  logic [TW-1:0]  j_dec;
  logic [TW-1:0]  k;
  logic [EW-1:0]  key;
  logic [EW-1:0]  cur;
  logic [EW-1:0]  pend;
  logic           pend_valid;
  logic [VW-1:0]  ca;
  logic [VW-1:0]  cb;
  logic [CW-1:0]  taken;
  logic [CW-1:0]  sv;
  logic           sw_valid;
  logic [VW-1:0]  sw_addr;
  logic           store_ok;
  logic           shift;
  logic           out_free;
  logic           out_load;

  logic           e_we;
  logic [AW-1:0]  e_waddr;
  logic [EW-1:0]  e_wdata;
  logic [AW-1:0]  e_raddr;
  logic [EW-1:0]  e_rdata;
  logic           s_we;
  logic [VW-1:0]  s_waddr;
  logic [VW-1:0]  s_wdata;
  logic [VW-1:0]  s_raddr;
  logic [VW-1:0]  s_rdata;

  // effective matrix side
  always_comb begin
    if (vcount == '0) begin
      n_side = CW'(1);
    end else if ({1'b0, vcount} > (kmuf_pkg::COUNT_W + 1)'(MAX_VERTICES)) begin
      n_side = CW'(MAX_VERTICES);
    end else begin
      n_side = CW'(vcount);
    end
  end

  assign col_inc  = CW'(col) + CW'(1);
  assign row_inc  = CW'(row) + CW'(1);
  assign j_dec    = j - TW'(1);
  assign store_ok = (row < col) && (CW'(col) < n_side) && (weight != kmuf_pkg::NO_EDGE)
                    && (total < TW'(DEPTH));
  assign shift    = $signed(e_rdata[WW-1:0]) > $signed(key[WW-1:0]);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_LOAD);

  // output register takes a new item
  assign out_load = out_free && (((state == S_EMIT) && pend_valid) || (state == S_FLUSH));

  // memory port steering
  always_comb begin
    e_we    = 1'b0;
    e_waddr = total[AW-1:0];
    e_wdata = {row, col, weight};
    e_raddr = k[AW-1:0];
    s_we    = 1'b0;
    s_waddr = sw_addr;
    s_wdata = ca;
    s_raddr = sv[VW-1:0];
    case (state)
      S_LOAD: begin
        e_we = in_valid && store_ok;
      end
      S_SRT_KEY: begin
        e_raddr = i[AW-1:0];
      end
      S_SRT_PREV: begin
        e_raddr = j_dec[AW-1:0];
      end
      S_SRT_CMP: begin
        e_we    = 1'b1;
        e_waddr = j[AW-1:0];
        e_wdata = shift ? e_rdata : key;
      end
      S_SRT_PUT: begin
        e_we    = 1'b1;
        e_waddr = j[AW-1:0];
        e_wdata = key;
      end
      S_INIT: begin
        s_we    = 1'b1;
        s_waddr = sv[VW-1:0];
        s_wdata = sv[VW-1:0];
      end
      S_EDGE: begin
        s_raddr = e_rdata[EW-1:WW+VW];
      end
      S_RDA: begin
        s_raddr = cur[WW+VW-1:WW];
      end
      S_SWEEP: begin
        s_we = sw_valid && (s_rdata == cb);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      vcount     <= kmuf_pkg::VCOUNT_RESET;
      row        <= '0;
      col        <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      sw_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        // take matrix entries
        S_LOAD: begin
          if (in_valid) begin
            if (store_ok) begin
              total <= total + TW'(1);
            end
            if (col_inc >= n_side) begin
              col <= '0;
              row <= row_inc[VW-1:0];
              if (row_inc >= n_side) begin
                n_run <= n_side;
                i     <= TW'(1);
                state <= S_SRT_KEY;
              end
            end else begin
              col <= col_inc[VW-1:0];
            end
          end
        end
        // insertion sort, stable on equal weights
        S_SRT_KEY: begin
          if (i >= total) begin
            sv    <= '0;
            state <= S_INIT;
          end else begin
            state <= S_SRT_GET;
          end
        end
        S_SRT_GET: begin
          key   <= e_rdata;
          j     <= i;
          state <= S_SRT_PREV;
        end
        S_SRT_PREV: begin
          state <= S_SRT_CMP;
        end
        S_SRT_CMP: begin
          if (shift) begin
            j     <= j_dec;
            state <= (j_dec == '0) ? S_SRT_PUT : S_SRT_PREV;
          end else begin
            i     <= i + TW'(1);
            state <= S_SRT_KEY;
          end
        end
        S_SRT_PUT: begin
          i     <= i + TW'(1);
          state <= S_SRT_KEY;
        end
        // every vertex in its own set
        S_INIT: begin
          if (sv == n_run - CW'(1)) begin
            k          <= '0;
            taken      <= '0;
            pend_valid <= 1'b0;
            state      <= S_TEST;
          end else begin
            sv <= sv + CW'(1);
          end
        end
        // next edge or done
        S_TEST: begin
          if ((taken + CW'(1) < n_run) && (k < total)) begin
            state <= S_EDGE;
          end else begin
            state <= S_FLUSH;
          end
        end
        S_EDGE: begin
          cur   <= e_rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          ca    <= s_rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          cb <= s_rdata;
          k  <= k + TW'(1);
          if (s_rdata != ca) begin
            taken <= taken + CW'(1);
            state <= S_EMIT;
          end else begin
            state <= S_TEST;
          end
        end
        // hold newest edge, release the previous one
        S_EMIT: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              edge_valid  <= 1'b1;
              src_vertex  <= kmuf_pkg::VERTEX_W'(pend[EW-1:WW+VW]);
              dst_vertex  <= kmuf_pkg::VERTEX_W'(pend[WW+VW-1:WW]);
              edge_weight <= pend[WW-1:0];
              last        <= 1'b0;
            end
            pend       <= cur;
            pend_valid <= 1'b1;
            sv         <= '0;
            sw_valid   <= 1'b0;
            state      <= S_SWEEP;
          end
        end
        // relabel set cb as ca
        S_SWEEP: begin
          sw_valid <= (sv < n_run);
          sw_addr  <= sv[VW-1:0];
          if (sv < n_run) begin
            sv <= sv + CW'(1);
          end else if (!sw_valid) begin
            state <= S_TEST;
          end
        end
        // final item of the run
        S_FLUSH: begin
          if (out_free) begin
            last <= 1'b1;
            if (pend_valid) begin
              edge_valid  <= 1'b1;
              src_vertex  <= kmuf_pkg::VERTEX_W'(pend[EW-1:WW+VW]);
              dst_vertex  <= kmuf_pkg::VERTEX_W'(pend[WW+VW-1:WW]);
              edge_weight <= pend[WW-1:0];
            end else begin
              edge_valid  <= 1'b0;
              src_vertex  <= '0;
              dst_vertex  <= '0;
              edge_weight <= '0;
            end
            pend_valid <= 1'b0;
            total      <= '0;
            row        <= '0;
            col        <= '0;
            state      <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // edge list
  kmuf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // set labels
  kmuf_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (VW)
  ) u_set_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

/* design/kmuf_checker.sv */
// ----------------------------------------------------------------------------
// kmuf_checker
// Port-level checks for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
module kmuf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          edge_valid,
  input logic [kmuf_pkg::VERTEX_W-1:0] src_vertex,
  input logic [kmuf_pkg::VERTEX_W-1:0] dst_vertex,
  input logic [kmuf_pkg::WEIGHT_W-1:0] edge_weight,
  input logic                          last
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_vertex) && $stable(dst_vertex)
      && $stable(edge_weight) && $stable(last) && $stable(edge_valid))
    else $error("output item changed while stalled");

  // empty tree item is final and zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> last && src_vertex == '0 && dst_vertex == '0
      && edge_weight == '0)
    else $error("bad empty-tree item");

  // tree edge endpoints ordered
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> src_vertex < dst_vertex)
    else $error("edge endpoints out of order");

  // no-edge marker never emitted
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> edge_weight != kmuf_pkg::NO_EDGE)
    else $error("no-edge marker emitted as an edge");

endmodule

bind kruskal_mst_union_find kmuf_checker u_kmuf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .edge_valid  (edge_valid),
  .src_vertex  (src_vertex),
  .dst_vertex  (dst_vertex),
  .edge_weight (edge_weight),
  .last        (last)
);

/* bench/tb_kruskal_mst_union_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_mst_union_find
// Streams adjacency matrices into the spanning tree block and checks each
// tree edge against an in-bench Kruskal predictor with union-find, under
// random sender gaps and receiver stalls and several vertex counts.
// ----------------------------------------------------------------------------
module tb_kruskal_mst_union_find;

  localparam int EDGE_CAP = kmuf_pkg::MAX_VERTICES_DEF * (kmuf_pkg::MAX_VERTICES_DEF - 1) / 2;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                          edge_valid;
    logic [kmuf_pkg::VERTEX_W-1:0] src_vertex;
    logic [kmuf_pkg::VERTEX_W-1:0] dst_vertex;
    logic [kmuf_pkg::WEIGHT_W-1:0] edge_weight;
    logic                          last;
  } tree_edge_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [kmuf_pkg::COUNT_W-1:0]  cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic [kmuf_pkg::WEIGHT_W-1:0] weight;
  logic                          out_valid;
  logic                          out_ready;
  logic                          edge_valid;
  logic [kmuf_pkg::VERTEX_W-1:0] src_vertex;
  logic [kmuf_pkg::VERTEX_W-1:0] dst_vertex;
  logic [kmuf_pkg::WEIGHT_W-1:0] edge_weight;
  logic                          last;

  kruskal_mst_union_find uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .weight(weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_valid(edge_valid), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
    .edge_weight(edge_weight), .last(last)
  );

  // clock
  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  logic [kmuf_pkg::WEIGHT_W-1:0] weight_queue[$];
  tree_edge_t                    tree_expect[$];
  int                            mismatch_count = 0;
  int                            send_idle_pct = 0;
  int                            recv_stall_pct = 0;
  int                            cycle_count = 0;

  // predictor state
  logic [kmuf_pkg::COUNT_W-1:0]         side_reg;
  int                                   row_at, col_at, kept_total;
  int                                   kept_a[EDGE_CAP];
  int                                   kept_b[EDGE_CAP];
  logic signed [kmuf_pkg::WEIGHT_W-1:0] kept_w[EDGE_CAP];
  int                                   uf_parent[kmuf_pkg::MAX_VERTICES_DEF];
  logic [2:0]                           uf_rank[kmuf_pkg::MAX_VERTICES_DEF];

  function automatic int side_of(logic [kmuf_pkg::COUNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > kmuf_pkg::MAX_VERTICES_DEF) return kmuf_pkg::MAX_VERTICES_DEF;
    return int'(v);
  endfunction

  function automatic int find_root(int v);
    int r, nx, guard;
    r = v;
    guard = 0;
    while (uf_parent[r] != r && guard < kmuf_pkg::MAX_VERTICES_DEF) begin
      r = uf_parent[r];
      guard++;
    end
    while (uf_parent[v] != r) begin
      nx = uf_parent[v];
      uf_parent[v] = r;
      v = nx;
    end
    return r;
  endfunction

  // stable sort, then kruskal over the kept edges
  task automatic build_tree(int n);
    int i, j, k, x, y, ka, kb, taken;
    logic signed [kmuf_pkg::WEIGHT_W-1:0] kw;
    tree_edge_t e;
    for (i = 1; i < kept_total; i++) begin
      ka = kept_a[i]; kb = kept_b[i]; kw = kept_w[i];
      j = i;
      while (j > 0 && kept_w[j-1] > kw) begin
        kept_a[j] = kept_a[j-1]; kept_b[j] = kept_b[j-1]; kept_w[j] = kept_w[j-1];
        j--;
      end
      kept_a[j] = ka; kept_b[j] = kb; kept_w[j] = kw;
    end
    for (i = 0; i < n; i++) begin
      uf_parent[i] = i;
      uf_rank[i] = 3'd0;
    end
    taken = 0;
    k = 0;
    while (taken + 1 < n && k < kept_total) begin
      x = find_root(kept_a[k]);
      y = find_root(kept_b[k]);
      if (x != y) begin
        e.edge_valid = 1'b1;
        e.src_vertex = kmuf_pkg::VERTEX_W'(kept_a[k]);
        e.dst_vertex = kmuf_pkg::VERTEX_W'(kept_b[k]);
        e.edge_weight = kept_w[k];
        e.last = 1'b0;
        tree_expect.push_back(e);
        taken++;
        if (uf_rank[x] < uf_rank[y]) uf_parent[x] = y;
        else if (uf_rank[x] > uf_rank[y]) uf_parent[y] = x;
        else begin
          uf_parent[y] = x;
          uf_rank[x] = uf_rank[x] + 3'd1;
        end
      end
      k++;
    end
    if (taken == 0) begin
      e = '0;
      e.last = 1'b1;
      tree_expect.push_back(e);
    end else begin
      tree_expect[tree_expect.size()-1].last = 1'b1;
    end
    row_at = 0;
    col_at = 0;
    kept_total = 0;
  endtask

  task automatic take_entry(logic [kmuf_pkg::WEIGHT_W-1:0] w);
    int n;
    n = side_of(side_reg);
    if (row_at < col_at && col_at < n && w != kmuf_pkg::NO_EDGE
        && kept_total < EDGE_CAP) begin
      kept_a[kept_total] = row_at;
      kept_b[kept_total] = col_at;
      kept_w[kept_total] = w;
      kept_total++;
    end
    col_at++;
    if (col_at >= n) begin
      col_at = 0;
      row_at++;
      if (row_at >= n) build_tree(n);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      weight <= '0;
    end else begin
      if (in_valid && in_ready) take_entry(weight);
      if (!in_valid || in_ready) begin
        if (weight_queue.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          in_valid <= 1'b1;
          weight <= weight_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tree_edge_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (tree_expect.size() == 0) begin
          report_mismatch("unexpected item", 32'({src_vertex, dst_vertex}), 32'(0));
        end else begin
          want = tree_expect.pop_front();
          if (edge_valid !== want.edge_valid)
            report_mismatch("edge_valid", 32'(edge_valid), 32'(want.edge_valid));
          if (src_vertex !== want.src_vertex)
            report_mismatch("src_vertex", 32'(src_vertex), 32'(want.src_vertex));
          if (dst_vertex !== want.dst_vertex)
            report_mismatch("dst_vertex", 32'(dst_vertex), 32'(want.dst_vertex));
          if (edge_weight !== want.edge_weight)
            report_mismatch("edge_weight", 32'(edge_weight), 32'(want.edge_weight));
          if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sender holds off until the block has delivered everything
  task automatic wait_drained();
    while (weight_queue.size() > 0 || in_valid || tree_expect.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_side(logic [kmuf_pkg::COUNT_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_reg = v;
  endtask

  function automatic logic [kmuf_pkg::WEIGHT_W-1:0] rand_weight(int sparse_pct);
    int pick;
    pick = int'($urandom_range(99));
    if (pick < sparse_pct) return kmuf_pkg::NO_EDGE;
    if (pick < sparse_pct + (100 - sparse_pct) / 3)
      return kmuf_pkg::WEIGHT_W'($urandom_range(7));
    return kmuf_pkg::WEIGHT_W'($urandom);
  endfunction

  task automatic push_random_matrix(int n, int sparse_pct);
    for (int i = 0; i < n * n; i++) weight_queue.push_back(rand_weight(sparse_pct));
  endtask

  initial begin
    int pushed;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    side_reg = kmuf_pkg::VCOUNT_RESET;
    row_at = 0;
    col_at = 0;
    kept_total = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties, no-edge marker, default side of 4
    weight_queue.push_back(21'd7);            // diagonal
    weight_queue.push_back(21'h100000);       // most negative
    weight_queue.push_back(21'h0FFFFF);       // most positive
    weight_queue.push_back(kmuf_pkg::NO_EDGE);
    weight_queue.push_back(21'h1FFFFF);       // lower triangle
    weight_queue.push_back(kmuf_pkg::NO_EDGE);
    weight_queue.push_back(21'd5);
    weight_queue.push_back(21'd5);
    weight_queue.push_back(21'd3);
    weight_queue.push_back(21'd3);
    weight_queue.push_back(21'd0);
    weight_queue.push_back(21'd5);
    for (int i = 0; i < 4; i++) weight_queue.push_back(21'h1AAAAA);
    // single vertex: one entry, empty tree
    write_side(7'd1);
    weight_queue.push_back(21'd1);
    // zero side acts as one
    write_side(7'd0);
    weight_queue.push_back(kmuf_pkg::NO_EDGE);
    // two vertices with no edge
    write_side(7'd2);
    for (int i = 0; i < 4; i++) weight_queue.push_back(kmuf_pkg::NO_EDGE);

    // random part over idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      pushed = 0;
      while (pushed < 70) begin
        n = ($urandom_range(9) == 0) ? int'($urandom_range(9, 12))
                                     : int'($urandom_range(2, 6));
        write_side(7'(n));
        push_random_matrix(n, int'($urandom_range(3)) * 20);
        pushed += n * n;
      end
    end
    write_side(kmuf_pkg::VCOUNT_RESET);
    push_random_matrix(4, 10);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && tree_expect.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/kmuf_pkg.sv
design/kmuf_ram.sv
design/kruskal_mst_union_find.sv
design/kmuf_checker.sv
bench/tb_kruskal_mst_union_find.sv
